// File: rtl/core/plm_pkg.sv
// Package for the peak and RMS level meter: beat types, widths, register
// indexes, reset values and the command/status structs between controller
// and datapath. Depends on nothing.
`default_nettype none

package plm_pkg;

    // Fixed field and state widths
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 3;
    localparam int LEVEL_W  = 16;
    localparam int ACH_W    = 4;
    localparam int FPB_W    = 11;
    localparam int BPR_W    = 16;
    localparam int FIB_W    = 10;
    localparam int FC_W     = 26;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Channel and frame limits
    localparam int MAX_CHANNELS_DEFAULT = 8;
    localparam int CHANNEL_SPAN         = 8;
    localparam logic [FPB_W-1:0] FRAME_LIMIT = 11'd1024;

    // Register reset values
    localparam logic [ACH_W-1:0] ACTIVE_RESET = 4'd2;
    localparam logic [FPB_W-1:0] FPB_RESET    = 11'd16;
    localparam logic [BPR_W-1:0] BPR_RESET    = 16'd2756;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BLOCK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_REPORT = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            channel;
    } in_beat_t;

    typedef struct packed {
        logic [CH_W-1:0]    report_channel;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
        logic               last_report;
    } out_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic square;
        logic update;
        logic report_sel;
        logic chan_first;
        logic chan_next;
        logic start_div;
        logic start_sqrt;
        logic load_out;
        logic clear;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_active;
        logic report;
        logic div_done;
        logic sqrt_done;
        logic last_ch;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/plm_div.sv
// Restoring divider, one quotient bit per cycle, for the mean square.
// Depends on nothing.
`default_nettype none

module plm_div #(
    parameter int DW = 48,
    parameter int VW = 26
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VW:0] trial;
    logic [VW:0] diff;

    // Trial subtraction of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift one quotient bit in per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= diff[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/plm_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on nothing.
`default_nettype none

module plm_sqrt #(
    parameter int IW = 48
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [IW-1:0]   operand,
    output logic      [IW/2-1:0] root,
    output logic                 done
);

    localparam int RW    = IW / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [IW-1:0]    val_reg;
    logic [RW:0]      rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RW+2:0] shifted;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;

    // Bring down the next two bits and try the odd step
    assign shifted = {rem_reg, val_reg[IW-1:IW-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = shifted - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= {val_reg[IW-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_reg  <= diff[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/plm_dp.sv
// Datapath of the level meter: configuration registers, per-channel peak and
// square-sum stores, frame/block counters, divider, root unit, output register.
// Depends on plm_pkg, plm_div and plm_sqrt.
`default_nettype none

module plm_dp #(
    parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [plm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire plm_pkg::in_beat_t                s_data,
    output plm_pkg::out_beat_t                    m_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    input  wire plm_pkg::ctrl_cmd_t               cmd,
    output plm_pkg::dp_status_t                   status
);

    import plm_pkg::*;

    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_LIM = (MAX_CHANNELS < CHANNEL_SPAN) ? MAX_CHANNELS : CHANNEL_SPAN;
    localparam int ROOT_W = SUM_W / 2;

    // Configuration
    logic [ACH_W-1:0] ach_reg;
    logic [FPB_W-1:0] fpb_reg;
    logic [BPR_W-1:0] bpr_reg;

    // Accumulators and counters
    logic [LEVEL_W-1:0] peak_reg [MAX_CHANNELS];
    logic [SUM_W-1:0]   sum_reg  [MAX_CHANNELS];
    logic [FIB_W-1:0]   fib_reg;
    logic [BPR_W-1:0]   bc_reg;
    logic [FC_W-1:0]    fc_reg;

    // Per-item working registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [LEVEL_W-1:0]         mag_reg;
    logic [LEVEL_W-1:0]         peak_rd_reg;
    logic [SUM_W-1:0]           sum_rd_reg;
    logic [CH_W-1:0]            rep_reg;

    out_beat_t out_reg;
    logic      out_valid_reg;

    logic [ACH_W-1:0]   nch;
    logic [FPB_W-1:0]   fpb_eff;
    logic [BPR_W-1:0]   bpr_eff;
    logic [IDX_W-1:0]   ch_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [SAMPLE_W:0]  mag_wide;
    logic [2*LEVEL_W-1:0] sq_full;
    logic [SUM_W:0]     sum_add;
    logic [FPB_W-1:0]   fib_inc;
    logic [BPR_W-1:0]   bc_inc;
    logic               is_last;
    logic               block_end;
    logic               block_hold;
    logic               div_done;
    logic               sqrt_done;
    logic [SUM_W-1:0]   quotient;
    logic [ROOT_W-1:0]  root;

    // Clamp the registers to their working ranges
    always_comb begin
        if (ach_reg == '0) begin
            nch = ACH_W'(1);
        end else if (ach_reg > ACH_W'(CH_LIM)) begin
            nch = ACH_W'(CH_LIM);
        end else begin
            nch = ach_reg;
        end
        if (fpb_reg == '0) begin
            fpb_eff = FPB_W'(1);
        end else if (fpb_reg > FRAME_LIMIT) begin
            fpb_eff = FRAME_LIMIT;
        end else begin
            fpb_eff = fpb_reg;
        end
        bpr_eff = (bpr_reg == '0) ? BPR_W'(1) : bpr_reg;
    end

    // Store addressing: one read address a cycle
    assign ch_idx = IDX_W'(ch_reg);
    assign rd_idx = cmd.report_sel ? IDX_W'(rep_reg) : ch_idx;

    // Magnitude, square and saturating sum
    assign mag_wide = sample_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, sample_reg})
                                             : {1'b0, sample_reg};
    assign sq_full  = mag_reg * mag_reg;
    assign sum_add  = {1'b0, sum_rd_reg} + (SUM_W+1)'(sq_reg);

    // Frame and block bookkeeping
    assign is_last    = ({1'b0, ch_reg} == (nch - 1'b1));
    assign fib_inc    = {1'b0, fib_reg} + 1'b1;
    assign block_end  = (fib_inc >= fpb_eff);
    assign bc_inc     = bc_reg + 1'b1;
    assign block_hold = (bc_inc != '0) && (bc_inc < bpr_eff);

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ach_reg <= ACTIVE_RESET;
            fpb_reg <= FPB_RESET;
            bpr_reg <= BPR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_CHANNELS:   ach_reg <= cfg_data[ACH_W-1:0];
                CFG_FRAMES_PER_BLOCK:  fpb_reg <= cfg_data[FPB_W-1:0];
                CFG_BLOCKS_PER_REPORT: bpr_reg <= cfg_data[BPR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the beat, then square and read the stores
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_data.sample;
            ch_reg     <= s_data.channel;
        end
        if (cmd.square) begin
            mag_reg     <= mag_wide[LEVEL_W-1:0];
            peak_rd_reg <= peak_reg[rd_idx];
            sum_rd_reg  <= sum_reg[rd_idx];
        end
    end

    // Square registered in the cycle after the magnitude
    always_ff @(posedge aclk) begin
        sq_reg <= sq_full[SQ_W-1:0];
    end

    // Update accumulators and counters; clear after a report
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                peak_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
            fc_reg <= '0;
        end else if (cmd.update) begin
            if (mag_reg > peak_rd_reg) begin
                peak_reg[ch_idx] <= mag_reg;
            end
            sum_reg[ch_idx] <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            if (is_last && (fc_reg != {FC_W{1'b1}})) begin
                fc_reg <= fc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fib_reg <= '0;
            bc_reg  <= '0;
        end else if (cmd.update && is_last) begin
            if (!block_end) begin
                fib_reg <= fib_inc[FIB_W-1:0];
            end else begin
                fib_reg <= '0;
                bc_reg  <= block_hold ? bc_inc : '0;
            end
        end
    end

    // Step through the channels of a report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_reg <= '0;
        end else if (cmd.chan_first) begin
            rep_reg <= '0;
        end else if (cmd.chan_next) begin
            rep_reg <= rep_reg + 1'b1;
        end
    end

    plm_div #(
        .DW(SUM_W),
        .VW(FC_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (sum_reg[rd_idx]),
        .divisor  (fc_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    plm_sqrt #(
        .IW(SUM_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_sqrt),
        .operand (quotient),
        .root    (root),
        .done    (sqrt_done)
    );

    // Output register: load a report beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.report_channel <= rep_reg;
            out_reg.peak_level     <= peak_reg[rd_idx];
            out_reg.rms_level      <= root[LEVEL_W-1:0];
            out_reg.last_report    <= ({1'b0, rep_reg} == (nch - 1'b1));
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    assign status.in_active = ({1'b0, s_data.channel} < nch);
    assign status.report    = is_last && block_end && !block_hold;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.last_ch   = ({1'b0, rep_reg} == (nch - 1'b1));
    assign status.out_free  = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

// File: rtl/core/plm_ctrl.sv
// Controller of the level meter: sequences accumulation of a beat and the
// per-channel divide, root and output steps of a report. Depends on plm_pkg.
`default_nettype none

module plm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire plm_pkg::dp_status_t  status,
    output plm_pkg::ctrl_cmd_t        cmd
);

    import plm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_MULT,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQRT_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid && status.in_active) begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                state_next = S_MULT;
            end
            // Let the square register settle on the new magnitude
            S_MULT: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                if (status.report) begin
                    cmd.chan_first = 1'b1;
                    state_next     = S_DIV_START;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV_START: begin
                cmd.report_sel = 1'b1;
                cmd.start_div  = 1'b1;
                state_next     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.start_sqrt = 1'b1;
                    state_next     = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (status.sqrt_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                cmd.report_sel = 1'b1;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (status.last_ch) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.chan_next = 1'b1;
                        state_next    = S_DIV_START;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/peak_rms_level_meter.sv
// Peak and RMS level meter. An input beat passes through accept, magnitude,
// square and accumulate states; a beat of an inactive channel is dropped in its accept
// cycle. For each active channel a report runs the bit-serial divider and then
// the bit-serial root unit; the last report beat may wait in the output register
// while new samples are taken. Synchronous active-low reset restores register
// defaults and zeroes the accumulators, counters and output valid flag.
`default_nettype none

module peak_rms_level_meter #(
    parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [plm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire plm_pkg::in_beat_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output plm_pkg::out_beat_t                   m_data
);

    import plm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    plm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plm_dp #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: test/peak_rms_level_meter_test.sv
// Self-checking testbench for peak_rms_level_meter: bursty sample beats, a
// stalling report sink and an in-bench level predictor checked beat by beat.
// Depends on plm_pkg and the peak_rms_level_meter RTL only.
`timescale 1ns / 1ps

module peak_rms_level_meter_test;

    import plm_pkg::*;

    localparam int CHANNELS      = MAX_CHANNELS_DEFAULT;
    localparam int CHANNEL_LIMIT = (CHANNELS < CHANNEL_SPAN) ? CHANNELS : CHANNEL_SPAN;
    localparam int FRAME_CAP     = 1024;
    localparam int DRAIN_CYCLES  = 800;
    localparam int LONG_HOLD     = 3000;
    localparam int RANDOM_TARGET = 280;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned SUM_CEILING = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {SINK_FREE, SINK_PATCHY, SINK_SLOW} sink_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;

    // Beats waiting to be offered and reports waiting to be seen
    in_beat_t  sample_queue[$];
    out_beat_t pending_reports[$];
    int        inputs_offered = 0;
    int        inputs_taken   = 0;
    int        active_items   = 0;
    int        fail_count     = 0;
    bit        hold_request   = 1'b0;

    // Predictor copy of the registers and accumulators
    logic [ACH_W-1:0]   ach_reg = ACTIVE_RESET;
    logic [FPB_W-1:0]   fpb_reg = FPB_RESET;
    logic [BPR_W-1:0]   bpr_reg = BPR_RESET;
    logic [LEVEL_W-1:0] peak_acc [CHANNELS];
    logic [SUM_W-1:0]   square_acc [CHANNELS];
    int                 frame_in_block = 0;
    logic [15:0]        blocks_done = '0;
    logic [FC_W-1:0]    frames_seen = '0;

    peak_rms_level_meter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("peak_rms_level_meter verification failed");
        $finish;
    end

    function automatic int active_count();
        int n;
        n = ach_reg;
        if (n == 0) n = 1;
        if (n > CHANNEL_LIMIT) n = CHANNEL_LIMIT;
        return n;
    endfunction

    // Floor square root of the mean square, cut to the level width
    function automatic logic [LEVEL_W-1:0] rms_of(logic [SUM_W-1:0] total,
                                                  logic [FC_W-1:0] frames);
        longint unsigned mean;
        longint unsigned root;
        longint unsigned trial;
        if (frames == 0) return '0;
        mean = total / frames;
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean) root = trial;
        end
        return root[LEVEL_W-1:0];
    endfunction

    // Accumulate one accepted sample beat and queue any report it completes
    task automatic meter_step(input in_beat_t beat);
        int              nch;
        int              ch;
        int              mag;
        int              fpb;
        int              bpr;
        longint unsigned sq;
        out_beat_t       rep;
        nch = active_count();
        ch  = beat.channel;
        if (ch >= nch) return;
        mag = $signed(beat.sample);
        if (mag < 0) mag = -mag;
        if (mag > peak_acc[ch]) peak_acc[ch] = LEVEL_W'(mag);
        sq = longint'(mag) * longint'(mag);
        if (square_acc[ch] > SUM_CEILING - sq) square_acc[ch] = SUM_CEILING[SUM_W-1:0];
        else square_acc[ch] = SUM_W'(square_acc[ch] + sq);
        if (ch != nch - 1) return;

        // frame complete
        if (frames_seen != '1) frames_seen++;
        fpb = fpb_reg;
        if (fpb == 0) fpb = 1;
        if (fpb > FRAME_CAP) fpb = FRAME_CAP;
        frame_in_block++;
        if (frame_in_block < fpb) return;

        // block complete
        frame_in_block = 0;
        bpr = bpr_reg;
        if (bpr == 0) bpr = 1;
        blocks_done = blocks_done + 16'd1;
        if (blocks_done != 0 && blocks_done < bpr) return;

        // report, then clear every channel
        blocks_done = '0;
        for (int i = 0; i < nch; i++) begin
            rep.report_channel = i[CH_W-1:0];
            rep.peak_level     = peak_acc[i];
            rep.rms_level      = rms_of(square_acc[i], frames_seen);
            rep.last_report    = (i == nch - 1);
            pending_reports.push_back(rep);
        end
        for (int i = 0; i < CHANNELS; i++) begin
            peak_acc[i]   = '0;
            square_acc[i] = '0;
        end
        frames_seen = '0;
    endtask

    // Sample the handshakes: check reports first, then predict from the input
    always @(posedge aclk) begin : monitor
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected report beat: channel %0d peak %0d rms %0d last %0d",
                           m_data.report_channel, m_data.peak_level, m_data.rms_level,
                           m_data.last_report);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_data.report_channel !== want.report_channel) begin
                        $error("report_channel: expected %0d, got %0d",
                               want.report_channel, m_data.report_channel);
                        fail_count++;
                    end
                    if (m_data.peak_level !== want.peak_level) begin
                        $error("peak_level: expected %0d, got %0d",
                               want.peak_level, m_data.peak_level);
                        fail_count++;
                    end
                    if (m_data.rms_level !== want.rms_level) begin
                        $error("rms_level: expected %0d, got %0d",
                               want.rms_level, m_data.rms_level);
                        fail_count++;
                    end
                    if (m_data.last_report !== want.last_report) begin
                        $error("last_report: expected %0d, got %0d",
                               want.last_report, m_data.last_report);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                meter_step(s_data);
                inputs_taken++;
            end
        end
    end

    // Offer queued beats in bursts with random gaps between them
    always @(negedge aclk) begin : sender
        int burst_left;
        int gap_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!s_valid || inputs_taken == inputs_offered) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                s_data  <= sample_queue.pop_front();
                s_valid <= 1'b1;
                inputs_offered++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Report sink: stretches of free, patchy and slow acceptance, plus one long hold
    always @(negedge aclk) begin : sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        bit         hold_served;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            mode        = SINK_FREE;
            mode_left   = 0;
            hold_left   = 0;
            hold_served = 1'b0;
        end else begin
            if (hold_request && !hold_served) begin
                hold_left   = LONG_HOLD;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 256);
                end
                mode_left--;
                case (mode)
                    SINK_FREE:   m_ready <= 1'b1;
                    SINK_PATCHY: m_ready <= ($urandom_range(0, 1) == 1);
                    default:     m_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_ACTIVE_CHANNELS:   ach_reg = value[ACH_W-1:0];
            CFG_FRAMES_PER_BLOCK:  fpb_reg = value[FPB_W-1:0];
            CFG_BLOCKS_PER_REPORT: bpr_reg = value[BPR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] channels,
                             input logic [CFG_DATA_W-1:0] frames,
                             input logic [CFG_DATA_W-1:0] blocks);
        write_reg(CFG_ACTIVE_CHANNELS, channels);
        write_reg(CFG_FRAMES_PER_BLOCK, frames);
        write_reg(CFG_BLOCKS_PER_REPORT, blocks);
    endtask

    // Hold until every beat is taken and every report seen, then let the core go idle
    task automatic settle();
        while (sample_queue.size() != 0 || inputs_taken != inputs_offered ||
               pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] value, input int ch);
        in_beat_t beat;
        beat.sample  = value;
        beat.channel = ch[CH_W-1:0];
        if (ch < active_count()) active_items++;
        sample_queue.push_back(beat);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            4: begin
                v = SAMPLE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Whole frames with random content; now and then shuffled or with a stray beat
    task automatic push_frames(input int count);
        int nch;
        int order [CHANNEL_SPAN];
        int k;
        int tmp;
        int stray;
        nch = active_count();
        for (int f = 0; f < count; f++) begin
            for (int j = 0; j < nch; j++) order[j] = j;
            if ($urandom_range(0, 4) == 0) begin
                for (int j = nch - 1; j > 0; j--) begin
                    k        = $urandom_range(0, j);
                    tmp      = order[j];
                    order[j] = order[k];
                    order[k] = tmp;
                end
            end
            for (int j = 0; j < nch; j++) begin
                if ($urandom_range(0, 11) == 0) begin
                    // an idle channel, or a repeat of an active one
                    if (nch < CHANNEL_SPAN && $urandom_range(0, 1))
                        stray = $urandom_range(nch, CHANNEL_SPAN - 1);
                    else
                        stray = $urandom_range(0, nch - 1);
                    push_sample(pick_sample(), stray);
                end
                push_sample(pick_sample(), order[j]);
            end
        end
    endtask

    initial begin : stimulus
        int          phase;
        logic [15:0] ach;
        logic [15:0] fpb;
        logic [15:0] bpr;

        for (int i = 0; i < CHANNELS; i++) begin
            peak_acc[i]   = '0;
            square_acc[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero in every register acts as one: each channel 0 beat is a report
        configure(16'd0, 16'd0, 16'd0);
        push_sample(16'h8000, 0);
        push_sample(16'h7FFF, 0);
        push_sample(16'h1234, 3);
        push_sample(16'h0000, 0);
        push_sample(16'hFFFF, 0);
        push_sample(16'h0001, 0);
        settle();

        // Channel count above range clamps to eight; one shuffled frame
        configure(16'd15, 16'd1, 16'd1);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        push_sample(16'h8000, 3);
        push_sample(16'h7FFF, 0);
        push_sample(16'hFFFF, 5);
        push_sample(16'h0000, 1);
        push_sample(16'h5555, 6);
        push_sample(16'hAAAA, 2);
        push_sample(16'h0001, 4);
        push_sample(16'h8001, 7);
        settle();

        // Registers lowered mid-count, a repeated channel, and an early frame end
        configure(16'd2, 16'd3, 16'd65535);
        push_sample(16'h8000, 0);
        push_sample(16'h7FFF, 1);
        push_sample(16'd100, 0);
        push_sample(-16'sd100, 0);
        push_sample(-16'sd5, 1);
        settle();
        write_reg(CFG_FRAMES_PER_BLOCK, 16'd1);
        push_sample(16'd7, 0);
        push_sample(16'h8000, 1);
        settle();
        write_reg(CFG_BLOCKS_PER_REPORT, 16'd1);
        push_sample(16'd12345, 1);
        push_sample(16'h0000, 0);
        settle();

        // Random phases; the second one runs against a long sink hold
        active_items = 0;
        phase = 0;
        while (active_items < RANDOM_TARGET) begin
            if (phase == 1) begin
                configure(16'd4, 16'd1, 16'd1);
                hold_request = 1'b1;
                push_frames(40);
            end else begin
                ach = 16'(($urandom_range(0, 7) == 0) ?
                      (($urandom_range(0, 1)) ? 0 : $urandom_range(9, 15)) :
                      $urandom_range(1, 8));
                fpb = 16'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
                bpr = 16'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
                configure(ach, fpb, bpr);
                push_frames($urandom_range(4, 16));
            end
            settle();
            phase++;
        end

        // Frame length over range holds the block open; lowering it ends the block
        configure(16'd1, 16'd2047, 16'd1);
        push_frames(40);
        settle();
        write_reg(CFG_FRAMES_PER_BLOCK, 16'd1);
        push_frames(1);
        settle();

        if (fail_count == 0) begin
            $display("peak_rms_level_meter verification clean");
        end else begin
            $display("peak_rms_level_meter verification failed");
        end
        $finish;
    end

endmodule
